// File: hw/rtl/ps2_keyboard_receiver_decoder_unit_macros.svh
// Assertion macros for the PS/2 keyboard receiver and decoder.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef PS2_KEYBOARD_RECEIVER_DECODER_UNIT_MACROS_SVH
`define PS2_KEYBOARD_RECEIVER_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PS2KRD_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("ps2krd assertion failed");

// Next-cycle implication, checked out of reset.
`define PS2KRD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("ps2krd assertion failed");

`endif

// File: hw/rtl/ps2krd_pkg.sv
// Shared types, constants and the set-2 key table for the PS/2 receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ps2krd_pkg;

  localparam int unsigned TICK_WIDTH_DEF = 32;
  localparam int unsigned FIFO_DEPTH_DEF = 2;
  localparam int unsigned TICK_IN_W      = 32;
  localparam int unsigned IN_TDATA_W     = 40;
  localparam int unsigned OUT_TDATA_W    = 24;
  localparam int unsigned FRAME_W        = 11;

  localparam logic [3:0] FRAME_BITS   = 4'd11;
  localparam logic [7:0] TIMEOUT_RST  = 8'h02;

  localparam logic [7:0] CODE_RELEASE = 8'hf0;
  localparam logic [7:0] CODE_EXTEND  = 8'he0;
  localparam logic [7:0] CODE_PAUSE   = 8'he1;
  localparam logic [7:0] PAUSE_KEY    = 8'h88;
  localparam logic [7:0] EXT_BIT      = 8'h80;
  localparam logic [7:0] CH_ALT       = 8'h8d;
  localparam logic [7:0] CH_SHIFT     = 8'h8e;
  localparam logic [7:0] CH_CTRL      = 8'h8f;
  localparam logic [7:0] LOWER_A      = 8'h61;
  localparam logic [7:0] LOWER_Z      = 8'h7a;
  localparam logic [7:0] CTRL_OFFSET  = 8'h60;
  localparam logic [7:0] SHIFT_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    PAUSE_IDLE = 2'd0,
    PAUSE_LAST = 2'd1,
    PAUSE_NEXT = 2'd2
  } pause_e;

  typedef struct packed {
    logic       parity_bad;
    logic       stop_bad;
    logic       start_bad;
    logic [7:0] scan_byte;
  } frame_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_valid;
    logic       parity_bad;
    logic       stop_bad;
    logic       start_bad;
    logic [7:0] scan_byte;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  localparam logic [7:0] KEYMAP [256] = '{
    8'h80,8'h89,8'h80,8'h85,8'h83,8'h81,8'h82,8'h8c, 8'h1b,8'h8a,8'h88,8'h86,8'h84,8'h09,8'h60,8'h80,
    8'h80,8'h8d,8'h8e,8'h80,8'h8f,8'h71,8'h31,8'h80, 8'h80,8'h80,8'h7a,8'h73,8'h61,8'h77,8'h32,8'h80,
    8'h80,8'h63,8'h78,8'h64,8'h65,8'h34,8'h33,8'h80, 8'h80,8'h20,8'h76,8'h66,8'h74,8'h72,8'h35,8'h80,
    8'h80,8'h6e,8'h62,8'h68,8'h67,8'h79,8'h36,8'h80, 8'h80,8'h8d,8'h6d,8'h6a,8'h75,8'h37,8'h38,8'h80,
    8'h80,8'h2c,8'h6b,8'h69,8'h6f,8'h30,8'h39,8'h80, 8'h80,8'h2e,8'h2f,8'h6c,8'h3b,8'h70,8'h2d,8'h80,
    8'h80,8'h80,8'h27,8'h80,8'h5b,8'h3d,8'h80,8'h80, 8'h90,8'h8e,8'h0d,8'h5d,8'h80,8'h5c,8'h80,8'h80,
    8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h08,8'h80, 8'h80,8'h31,8'h80,8'h34,8'h37,8'h80,8'h91,8'h80,
    8'h30,8'h2e,8'h32,8'h35,8'h36,8'h38,8'h1b,8'h92, 8'hab,8'h2b,8'h33,8'h2d,8'h2a,8'h39,8'h93,8'h80,
    8'h80,8'h80,8'h80,8'h87,8'h94,8'h80,8'h80,8'h80, 8'h95,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,
    8'h80,8'h8d,8'h80,8'h80,8'h8f,8'h80,8'h80,8'h80, 8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,
    8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80, 8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,
    8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80, 8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,
    8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80, 8'h80,8'h80,8'h2f,8'h80,8'h80,8'h80,8'h80,8'h80,
    8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80, 8'h80,8'h80,8'h0d,8'h80,8'h80,8'h80,8'h80,8'h80,
    8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80, 8'h80,8'h96,8'h80,8'ha0,8'h91,8'h80,8'h80,8'h80,
    8'h97,8'h98,8'ha3,8'h80,8'ha1,8'ha2,8'h80,8'h80, 8'h80,8'h80,8'ha4,8'h80,8'h99,8'ha5,8'h80,8'h80
  };

endpackage
`default_nettype wire

// File: hw/rtl/ps2krd_front.sv
// Bit receiver: timeout check, LSB-first shift, parity and frame checks.
// Depends on ps2krd_pkg; pushes one frame_t per completed 11-bit frame.
`timescale 1ns / 1ps
`default_nettype none
module ps2krd_front import ps2krd_pkg::*; #(
  parameter int unsigned TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 bit_valid_i,
  input  wire logic                 data_bit_i,
  input  wire logic [TICK_IN_W-1:0] tick_now_i,
  input  wire logic [7:0]           timeout_i,
  output logic                      push_o,
  output frame_t                    frame_o
);

  logic [TICK_WIDTH-1:0] last_q, last_d, now;
  logic [FRAME_W-1:0]    shift_q, shift_d, base_shift, new_shift;
  logic [3:0]            cnt_q, cnt_d, base_cnt, new_cnt;
  logic                  par_q, par_d, base_par, new_par;
  logic                  expired, done;

  always_comb begin
    now        = TICK_WIDTH'(tick_now_i);
    expired    = (last_q != '0) && ((now - last_q) > TICK_WIDTH'(timeout_i));
    base_shift = expired ? '0 : shift_q;
    base_cnt   = expired ? '0 : cnt_q;
    base_par   = expired ? 1'b0 : par_q;
    new_shift  = {data_bit_i, base_shift[FRAME_W-1:1]};
    new_cnt    = base_cnt + 4'd1;
    new_par    = base_par ^ data_bit_i;
    done       = (new_cnt == FRAME_BITS);
  end

  always_comb begin
    last_d  = last_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    par_d   = par_q;
    if (bit_valid_i) begin
      last_d = now;
      if (done) begin
        shift_d = '0;
        cnt_d   = '0;
        par_d   = 1'b0;
      end else begin
        shift_d = new_shift;
        cnt_d   = new_cnt;
        par_d   = new_par;
      end
    end
  end

  assign push_o               = bit_valid_i && done;
  assign frame_o.scan_byte    = new_shift[8:1];
  assign frame_o.start_bad    = new_shift[0];
  assign frame_o.stop_bad     = !new_shift[FRAME_W-1];
  assign frame_o.parity_bad   = new_par;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      shift_q <= '0;
      cnt_q   <= '0;
      par_q   <= 1'b0;
    end else begin
      last_q  <= last_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      par_q   <= par_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ps2krd_fifo.sv
// Short frame queue between the bit receiver and the key decoder.
// Depends on ps2krd_pkg for frame_t and fifo_status_t.
`timescale 1ns / 1ps
`default_nettype none
module ps2krd_fifo import ps2krd_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire frame_t wdata_i,
  input  wire logic   pop_i,
  output frame_t      rdata_o,
  output fifo_status_t status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frame_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign rdata_o        = mem_q[rd_q];
  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ps2krd_back.sv
// Key decoder: prefix tracking, modifier state, set-2 lookup, result register.
// Depends on ps2krd_pkg for KEYMAP, pause_e, frame_t and result_t.
`timescale 1ns / 1ps
`default_nettype none
module ps2krd_back import ps2krd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   frame_avail_i,
  input  wire frame_t frame_i,
  output logic        pop_o,
  output logic        res_valid_o,
  input  wire logic   res_ready_i,
  output result_t     res_o
);

  pause_e     pause_q, pause_d;
  logic       rel_q, rel_d, ext_q, ext_d;
  logic       shift_q, shift_d, ctrl_q, ctrl_d;
  logic       out_valid_q, out_valid_d;
  result_t    out_q, out_d;
  logic [7:0] byte_in, eff_code, key_ch, ch;
  logic       is_key, down, char_ok;

  assign pop_o   = frame_avail_i && (!out_valid_q || res_ready_i);
  assign byte_in = frame_i.scan_byte;
  assign is_key  = (byte_in != CODE_RELEASE) && (byte_in != CODE_EXTEND) &&
                   (byte_in != CODE_PAUSE) && (pause_q != PAUSE_NEXT);
  assign down    = !rel_q;

  always_comb begin
    eff_code = (pause_q == PAUSE_LAST) ? PAUSE_KEY : byte_in;
    if (ext_q) begin
      eff_code = eff_code | EXT_BIT;
    end
    key_ch = KEYMAP[eff_code];
  end

  // next state
  always_comb begin
    pause_d = pause_q;
    rel_d   = rel_q;
    ext_d   = ext_q;
    shift_d = shift_q;
    ctrl_d  = ctrl_q;
    if (pop_o) begin
      if (byte_in == CODE_RELEASE) begin
        rel_d = 1'b1;
      end else if (byte_in == CODE_EXTEND) begin
        ext_d = 1'b1;
      end else if (byte_in == CODE_PAUSE) begin
        pause_d = PAUSE_NEXT;
      end else if (pause_q == PAUSE_NEXT) begin
        pause_d = PAUSE_LAST;
      end else begin
        if (pause_q == PAUSE_LAST) begin
          pause_d = PAUSE_IDLE;
        end
        ext_d = 1'b0;
        rel_d = 1'b0;
        if (key_ch == CH_CTRL) begin
          ctrl_d = down;
        end
        if (key_ch == CH_SHIFT) begin
          shift_d = down;
        end
      end
    end
  end

  // outputs
  always_comb begin
    char_ok = is_key && !down && (key_ch != CH_ALT) && (key_ch != CH_CTRL) &&
              (key_ch != CH_SHIFT);
    ch = key_ch;
    if ((key_ch >= LOWER_A) && (key_ch <= LOWER_Z)) begin
      if (ctrl_q) begin
        ch = ch - CTRL_OFFSET;
      end
      if (shift_q) begin
        ch = ch - SHIFT_OFFSET;
      end
    end
    out_d = out_q;
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d      = 1'b1;
      out_d.scan_byte  = frame_i.scan_byte;
      out_d.start_bad  = frame_i.start_bad;
      out_d.stop_bad   = frame_i.stop_bad;
      out_d.parity_bad = frame_i.parity_bad;
      out_d.char_valid = char_ok;
      out_d.char_code  = char_ok ? ch : 8'h00;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_q     <= PAUSE_IDLE;
      rel_q       <= 1'b0;
      ext_q       <= 1'b0;
      shift_q     <= 1'b0;
      ctrl_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pause_q     <= pause_d;
      rel_q       <= rel_d;
      ext_q       <= ext_d;
      shift_q     <= shift_d;
      ctrl_q      <= ctrl_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ps2_keyboard_receiver_decoder_unit.sv
// PS/2 keyboard receiver and set-2 decoder, top level.
// Throughput: one data bit word per cycle; the receiver takes a bit every cycle while
// the frame queue has room, and the decoder retires one frame per cycle while its
// result register is free or being read; frames pass the queue, then that register.
// Reset: rst_ni clears all but queue memory and result data; the timeout goes to 2.
// Depends on ps2krd_pkg, ps2krd_front, ps2krd_fifo, ps2krd_back and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "ps2_keyboard_receiver_decoder_unit_macros.svh"
module ps2_keyboard_receiver_decoder_unit import ps2krd_pkg::*; #(
  parameter int unsigned TICK_WIDTH = TICK_WIDTH_DEF,
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [0] data_bit, [32:1] tick_now, [39:33] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [7:0] scan_byte, [8] start_bad, [9] stop_bad, [10] parity_bad,
  // [11] char_valid, [19:12] char_code, [23:20] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [7:0]             cfg_data_i
);

  logic         unused_pad;
  logic [7:0]   timeout_val_q;
  logic         bit_accept, fifo_push, fifo_pop;
  frame_t       push_frame, pop_frame;
  fifo_status_t fifo_st;
  result_t      res;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !fifo_st.full;
  assign bit_accept      = s_axis_tvalid_i && s_axis_tready_o;
  assign unused_pad      = |s_axis_tdata_i[IN_TDATA_W-1:TICK_IN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_val_q <= TIMEOUT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_val_q <= cfg_data_i;
    end
  end

  ps2krd_front #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bit_valid_i (bit_accept),
    .data_bit_i  (s_axis_tdata_i[0]),
    .tick_now_i  (s_axis_tdata_i[TICK_IN_W:1]),
    .timeout_i   (timeout_val_q),
    .push_o      (fifo_push),
    .frame_o     (push_frame)
  );

  ps2krd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fifo_push),
    .wdata_i  (push_frame),
    .pop_i    (fifo_pop),
    .rdata_o  (pop_frame),
    .status_o (fifo_st)
  );

  ps2krd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_avail_i (!fifo_st.empty),
    .frame_i       (pop_frame),
    .pop_o         (fifo_pop),
    .res_valid_o   (m_axis_tvalid_o),
    .res_ready_i   (m_axis_tready_i),
    .res_o         (res)
  );

  assign m_axis_tdata_o = {(OUT_TDATA_W - $bits(result_t))'(unused_pad & 1'b0), res};

  `PS2KRD_ASSERT_NOW(a_no_overflow, fifo_push, !fifo_st.full)
  `PS2KRD_ASSERT_NOW(a_no_underflow, fifo_pop, !fifo_st.empty)
  `PS2KRD_ASSERT_NEXT(a_cfg_write, cfg_valid_i && cfg_ready_o,
                      timeout_val_q == $past(cfg_data_i))

endmodule
`default_nettype wire
